@@ hdl/aid_pkg.sv @@
// Shared types and constants for the activity interval detector.
`default_nettype none
package aid_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CS_W     = 29;

  // interval queue entries; a power of two so the pointers wrap on their own
  localparam int unsigned QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SILENCE = 1'd1;

  // (ms + 5) / 10 == ((ms + 5) >> 1) / 5, the /5 done as multiply by reciprocal
  localparam logic [TIME_W:0]   ROUND_MS    = 33'd5;
  localparam logic [TIME_W-1:0] RECIP_5     = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP_SHIFT = 34;
  localparam logic [CS_W-1:0]   MAX_CS      = 29'd429496730;

  typedef struct packed {
    logic [TIME_W-1:0] begin_ms;
    logic [TIME_W-1:0] end_ms;
    logic              last;
  } aid_interval_t;

  // up to two intervals per sample, packed so that slot 0 fills first
  typedef struct packed {
    logic          valid0;
    logic          valid1;
    aid_interval_t entry0;
    aid_interval_t entry1;
  } aid_push_t;

endpackage
`default_nettype wire

@@ hdl/aid_front.sv @@
// Front end: config registers, run tracking, gap merge, interval generation.
`default_nettype none
module aid_front
  import aid_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 accept_i,
  input  wire logic [TIME_W-1:0]    time_i,
  input  wire logic [LEVEL_W-1:0]   level_i,
  input  wire logic                 last_i,
  output aid_push_t                 push_o
);

  logic [CFG_W-1:0]  thr_q, min_sil_q;
  logic              in_run_q, in_run_d;
  logic [TIME_W-1:0] run_begin_q, run_begin_d;
  logic [TIME_W-1:0] prev_q;
  logic              pend_valid_q, pend_valid_d;
  logic [TIME_W-1:0] pend_begin_q, pend_begin_d;
  logic [TIME_W-1:0] pend_end_q, pend_end_d;

  logic              active, close_en, merge, emit_a, emit_b, pv2;
  logic [TIME_W-1:0] close_b, close_e;
  logic [TIME_W:0]   merge_limit;
  aid_interval_t     rec_a, rec_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= '0;
      min_sil_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD:   thr_q     <= cfg_data_i;
        CFG_MIN_SILENCE: min_sil_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    active   = level_i > thr_q;
    // at most one run closes per sample: on a falling edge, or on last while active
    close_en = (!active && in_run_q) || (last_i && active);
    close_b  = (active && !in_run_q) ? time_i : run_begin_q;
    close_e  = active ? time_i : prev_q;
    // gap < min_silence  <=>  begin < pending_end + min_silence
    merge_limit = {1'b0, pend_end_q} + {{(TIME_W+1-CFG_W){1'b0}}, min_sil_q};
    merge    = pend_valid_q && ({1'b0, close_b} < merge_limit);
    emit_a   = close_en && pend_valid_q && !merge;
    pv2      = pend_valid_q || close_en;
    pend_begin_d = (close_en && !merge) ? close_b : pend_begin_q;
    pend_end_d   = close_en ? close_e : pend_end_q;
    emit_b   = last_i && pv2;

    pend_valid_d = pv2 && !last_i;
    in_run_d     = active && !last_i;
    run_begin_d  = (active && !in_run_q) ? time_i : run_begin_q;

    rec_a.begin_ms = pend_begin_q;
    rec_a.end_ms   = pend_end_q;
    rec_a.last     = !emit_b;
    rec_b.begin_ms = pend_begin_d;
    rec_b.end_ms   = pend_end_d;
    rec_b.last     = 1'b1;

    push_o.valid0 = accept_i && (emit_a || emit_b);
    push_o.valid1 = accept_i && emit_a && emit_b;
    push_o.entry0 = emit_a ? rec_a : rec_b;
    push_o.entry1 = rec_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q     <= 1'b0;
      run_begin_q  <= '0;
      prev_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_begin_q <= '0;
      pend_end_q   <= '0;
    end else if (accept_i) begin
      in_run_q     <= in_run_d;
      run_begin_q  <= run_begin_d;
      prev_q       <= time_i;
      pend_valid_q <= pend_valid_d;
      pend_begin_q <= pend_begin_d;
      pend_end_q   <= pend_end_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/aid_queue.sv @@
// Interval queue: two writes and one read per cycle.
`default_nettype none
module aid_queue
  import aid_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire aid_push_t push_i,
  input  wire logic      pop_i,
  output logic           room2_o,
  output logic           rd_valid_o,
  output aid_interval_t  rd_data_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] ROOM2_MAX = CW'(QUEUE_DEPTH - 2);

  aid_interval_t mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] wr_ptr1;

  assign wr_ptr1    = wr_ptr_q + AW'(1);
  assign room2_o    = count_q <= ROOM2_MAX;
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q + CW'(push_i.valid0) + CW'(push_i.valid1) - CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid0) mem_q[wr_ptr_q] <= push_i.entry0;
    if (push_i.valid1) mem_q[wr_ptr1]  <= push_i.entry1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + AW'(push_i.valid0) + AW'(push_i.valid1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + AW'(1);
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/aid_back.sv @@
// Back end: ms to centisecond rounding pipeline with output register.
`default_nettype none
module aid_back
  import aid_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           rd_valid_i,
  input  wire aid_interval_t  rd_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [CS_W-1:0]     start_cs_o,
  output logic [CS_W-1:0]     end_cs_o,
  output logic                last_o
);

  logic              v1_q, v2_q;
  logic [TIME_W-1:0] half_b_q, half_e_q;
  logic              last1_q;
  logic [TIME_W:0]   sum_b, sum_e;
  logic [2*TIME_W-1:0] prod_b, prod_e;
  logic              adv2, load1;

  assign adv2  = !v2_q || out_ready_i;
  assign load1 = !v1_q || adv2;
  assign pop_o = rd_valid_i && load1;

  assign sum_b  = {1'b0, rd_data_i.begin_ms} + ROUND_MS;
  assign sum_e  = {1'b0, rd_data_i.end_ms} + ROUND_MS;
  assign prod_b = half_b_q * RECIP_5;
  assign prod_e = half_e_q * RECIP_5;

  always_ff @(posedge clk_i) begin
    if (load1) begin
      half_b_q <= sum_b[TIME_W:1];
      half_e_q <= sum_e[TIME_W:1];
      last1_q  <= rd_data_i.last;
    end
    if (adv2) begin
      start_cs_o <= prod_b[RECIP_SHIFT +: CS_W];
      end_cs_o   <= prod_e[RECIP_SHIFT +: CS_W];
      last_o     <= last1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (load1) v1_q <= rd_valid_i;
      if (adv2)  v2_q <= v1_q;
    end
  end

  assign out_valid_o = v2_q;

endmodule
`default_nettype wire

@@ hdl/activity_interval_detector.sv @@
// Top level: threshold activity detector with gap merge and centisecond output.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata {level, sample_time_ms}, tlast is_last
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata {end_cs, start_cs}, tlast last_of_run
//  cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One sample per cycle; each sample yields zero to two intervals, and the
// output drains one interval per cycle while m_axis_tready is high, so the
// queue's single read port sets the sustained result rate. s_axis_tready drops
// while the queue has fewer than two free slots. Reset clears all control state
// at once; no clearing pass. cfg is always ready.
`default_nettype none
module activity_interval_detector
  import aid_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [47:0]          s_axis_tdata,  // [31:0] sample_time_ms, [47:32] level
  input  wire logic                 s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [63:0]               m_axis_tdata,  // [28:0] start_cs, [57:29] end_cs, zeros
  output logic                      m_axis_tlast,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  aid_push_t     push;
  aid_interval_t rd_data;
  logic          room2, rd_valid, pop, accept;
  logic [CS_W-1:0] start_cs, end_cs;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = room2;
  assign accept        = s_axis_tvalid && s_axis_tready;

  aid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .time_i      (s_axis_tdata[TIME_W-1:0]),
    .level_i     (s_axis_tdata[TIME_W +: LEVEL_W]),
    .last_i      (s_axis_tlast),
    .push_o      (push)
  );

  aid_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (pop),
    .room2_o    (room2),
    .rd_valid_o (rd_valid),
    .rd_data_o  (rd_data)
  );

  aid_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_valid_i  (rd_valid),
    .rd_data_i   (rd_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .start_cs_o  (start_cs),
    .end_cs_o    (end_cs),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, end_cs, start_cs};

`ifndef SYNTHESIS
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid1 |-> push.valid0 && !push.entry0.last && push.entry1.last)
    else $error("second interval pushed without first, or last flag misplaced");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid0 |-> room2)
    else $error("interval pushed while queue lacks room");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> rd_valid)
    else $error("pop from empty queue");

  a_cs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (start_cs <= MAX_CS) && (end_cs <= MAX_CS))
    else $error("centisecond value out of range");
`endif

endmodule
`default_nettype wire
